>>> rtl/pcm_frame_packer_top_defines.svh
// assertion macros for the pcm frame packer
`ifndef PCM_FRAME_PACKER_TOP_DEFINES_SVH
`define PCM_FRAME_PACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define PFP_CHECK(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("pcm frame packer check failed");

// trigger implies the condition in the next cycle
`define PFP_CHECK_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("pcm frame packer sequence check failed");

`else

`define PFP_CHECK(lbl, cond)
`define PFP_CHECK_NEXT(lbl, trig, cond)

`endif

`endif

>>> rtl/pfp_pkg.sv
// shared types and constants of the pcm frame packer
package pfp_pkg;

    // output sample width decoded from the sample_bits register
    typedef enum logic [1:0] {
        W_NONE,
        W_8,
        W_16,
        W_32
    } t_width;

    // one queued frame: bytes in emission order and index of the last one
    typedef struct packed {
        logic [63:0] data;
        logic [2:0]  last;
    } t_entry;

    localparam logic [1:0] CFG_CHAN = 2'd0;
    localparam logic [1:0] CFG_BITS = 2'd1;

    localparam logic [5:0] SB_8  = 6'd8;
    localparam logic [5:0] SB_16 = 6'd16;
    localparam logic [5:0] SB_32 = 6'd32;

    localparam logic [1:0] CHAN_RESET = 2'd2;
    localparam logic [5:0] BITS_RESET = 6'd16;

    // +1.0 in q2.30
    localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

endpackage

>>> rtl/pfp_front.sv
// front end: accepts frames, saturates and scales samples, packs bytes for the queue
module pfp_front
    import pfp_pkg::*;
#(
    parameter int QD = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic signed [31:0]        i_first_sample,
    input  logic signed [31:0]        i_second_sample,
    input  logic [1:0]                i_cfg_chan,
    input  logic [5:0]                i_cfg_bits,
    input  logic [$clog2(QD+1)-1:0]   i_q_count,
    output logic                      o_busy,
    output logic                      o_push,
    output t_entry                    o_entry
);

    localparam int CW = $clog2(QD+1);

    t_width n_width;
    logic [1:0] n_chan;

    logic r_v1, r_v2, r_v3;
    t_width r_w1, r_w2, r_w3;
    logic [1:0] r_c1, r_c2, r_c3;
    logic signed [31:0] r_smp [2];
    logic [31:0] r_op [2];
    logic r_neg2 [2];
    logic [31:0] r_q [2];
    logic r_neg3 [2];

    logic [31:0] n_op [2];
    logic n_neg [2];
    logic [31:0] n_q [2];
    logic [31:0] code [2];
    logic [CW:0] used;

    // a slot is reserved for every frame still in the pipeline
    assign used   = {1'b0, i_q_count} + (CW+1)'(r_v1) + (CW+1)'(r_v2) + (CW+1)'(r_v3);
    assign o_busy = (used >= (CW+1)'(QD));

    always_comb begin
        n_chan = (i_cfg_chan == 2'd3) ? 2'd2 : i_cfg_chan;
        unique case (i_cfg_bits)
            SB_8:    n_width = W_8;
            SB_16:   n_width = W_16;
            SB_32:   n_width = W_32;
            default: n_width = W_NONE;
        endcase
    end

    // saturate, then offset for 8 bit or take magnitude for the signed widths
    always_comb begin
        logic signed [31:0] v;
        for (int i = 0; i < 2; i++) begin
            v = r_smp[i];
            if (v > Q_ONE) begin
                v = Q_ONE;
            end else if (v < -Q_ONE) begin
                v = -Q_ONE;
            end
            if (r_w1 == W_8) begin
                n_op[i]  = 32'(v + Q_ONE);
                n_neg[i] = 1'b0;
            end else begin
                n_neg[i] = v[31];
                n_op[i]  = v[31] ? 32'(-v) : 32'(v);
            end
        end
    end

    // k*op as (op << n) - op with k = 2^n - 1, then drop the 30 fraction bits
    always_comb begin
        logic [62:0] opx;
        logic [62:0] prod;
        for (int i = 0; i < 2; i++) begin
            opx = {31'b0, r_op[i]};
            unique case (r_w2)
                W_8:     prod = (opx << 7) - opx;
                W_16:    prod = (opx << 15) - opx;
                W_32:    prod = (opx << 31) - opx;
                default: prod = '0;
            endcase
            n_q[i] = prod[61:30];
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            code[i] = r_neg3[i] ? (32'd0 - r_q[i]) : r_q[i];
        end
        o_entry.data = '0;
        o_entry.last = '0;
        unique case (r_w3)
            W_8: begin
                o_entry.data = {48'b0, code[1][7:0], code[0][7:0]};
                o_entry.last = (r_c3 == 2'd2) ? 3'd1 : 3'd0;
            end
            W_16: begin
                o_entry.data = {32'b0, code[1][15:0], code[0][15:0]};
                o_entry.last = (r_c3 == 2'd2) ? 3'd3 : 3'd1;
            end
            W_32: begin
                o_entry.data = {code[1], code[0]};
                o_entry.last = (r_c3 == 2'd2) ? 3'd7 : 3'd3;
            end
            default: begin
                o_entry.data = '0;
                o_entry.last = '0;
            end
        endcase
    end

    assign o_push = r_v3;

    // frames that produce no bytes never enter the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept && (n_width != W_NONE) && (n_chan != 2'd0);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_smp[0] <= i_first_sample;
            r_smp[1] <= i_second_sample;
            r_w1     <= n_width;
            r_c1     <= n_chan;
        end
        r_w2 <= r_w1;
        r_c2 <= r_c1;
        r_w3 <= r_w2;
        r_c3 <= r_c2;
        for (int i = 0; i < 2; i++) begin
            r_op[i]   <= n_op[i];
            r_neg2[i] <= n_neg[i];
            r_q[i]    <= n_q[i];
            r_neg3[i] <= r_neg2[i];
        end
    end

endmodule

>>> rtl/pfp_queue.sv
// frame queue between front and back end
module pfp_queue
    import pfp_pkg::*;
#(
    parameter int QD = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  t_entry                    i_entry,
    input  logic                      i_pop,
    output t_entry                    o_head,
    output logic                      o_empty,
    output logic [$clog2(QD+1)-1:0]   o_count
);

    localparam int AW = $clog2(QD);
    localparam int CW = $clog2(QD+1);

    t_entry r_mem [QD];
    t_entry r_head;
    logic [AW-1:0] r_wr, r_rd;
    logic [AW-1:0] rd_nxt;
    logic [CW-1:0] r_count;
    logic do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign rd_nxt  = do_pop ? ((r_rd == AW'(QD-1)) ? '0 : r_rd + 1'b1) : r_rd;
    assign o_head  = r_head;
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(QD-1)) ? '0 : r_wr + 1'b1;
            end
            r_rd    <= rd_nxt;
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end

    // head register tracks the entry at the read pointer, taking a write to that slot directly
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
        if (i_push && (r_wr == rd_nxt)) begin
            r_head <= i_entry;
        end else begin
            r_head <= r_mem[rd_nxt];
        end
    end

endmodule

>>> rtl/pfp_back.sv
// back end: serialises queued frames into one byte beat per cycle while the queue is not empty
module pfp_back
    import pfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_strobe,
    output logic [7:0]  o_byte_value,
    output logic        o_frame_end
);

    logic [2:0] r_idx;
    logic       r_strobe;
    logic [7:0] r_byte;
    logic       r_end;
    logic       last;

    assign last  = (r_idx == i_head.last);
    assign o_pop = !i_empty && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= !i_empty;
            if (!i_empty) begin
                r_idx <= last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= i_head.data[{r_idx, 3'b000} +: 8];
        r_end  <= last;
    end

    assign o_strobe     = r_strobe;
    assign o_byte_value = r_byte;
    assign o_frame_end  = r_end;

endmodule

>>> rtl/pcm_frame_packer_top.sv
// top level of the pcm frame packer
// Encodes a frame of two q2.30 samples as little-endian pcm bytes, one byte beat per
// cycle on o_strobe while a frame is queued, with o_frame_end on the last byte; the
// receiver cannot stall, so results must be taken as they appear. A frame is taken
// when start is high and busy is low; the front end takes a frame every cycle while
// the frame queue has room. A frame passes the front-end stages, the queue and the byte
// output register before its first byte appears. The serialiser sets the sustained
// rate: a frame has channels * sample_bits / 8 bytes, from 1 (mono, 8 bit) to 8 (stereo,
// 32 bit). Frames whose width setting is not 8, 16 or 32, or with zero channels, produce no bytes.
`include "pcm_frame_packer_top_defines.svh"

module pcm_frame_packer_top
    import pfp_pkg::*;
#(
    parameter int Q_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_first_sample,
    input  logic signed [31:0] i_second_sample,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [5:0]         i_cfg_data,
    output logic               o_strobe,
    output logic [7:0]         o_byte_value,
    output logic               o_frame_end
);

    localparam int CW = $clog2(Q_DEPTH+1);

    logic [1:0] r_chan;
    logic [5:0] r_bits;

    logic          accept;
    logic          push, pop, empty;
    t_entry        entry, head;
    logic [CW-1:0] q_count;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= CHAN_RESET;
            r_bits <= BITS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_CHAN) begin
                r_chan <= i_cfg_data[1:0];
            end else if (i_cfg_idx == CFG_BITS) begin
                r_bits <= i_cfg_data;
            end
        end
    end

    pfp_front #(.QD(Q_DEPTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_first_sample  (i_first_sample),
        .i_second_sample (i_second_sample),
        .i_cfg_chan      (r_chan),
        .i_cfg_bits      (r_bits),
        .i_q_count       (q_count),
        .o_busy          (busy),
        .o_push          (push),
        .o_entry         (entry)
    );

    pfp_queue #(.QD(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_count (q_count)
    );

    pfp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_byte_value (o_byte_value),
        .o_frame_end  (o_frame_end)
    );

    // queue never overfills and a push never lands on a full queue
    `PFP_CHECK(a_count_bound, q_count <= CW'(Q_DEPTH))
    `PFP_CHECK(a_push_room, !push || (q_count != CW'(Q_DEPTH)))
    // bytes of one frame go out in consecutive cycles
    `PFP_CHECK_NEXT(a_frame_contig, o_strobe && !o_frame_end, o_strobe)
    // no byte without a queued frame
    `PFP_CHECK_NEXT(a_strobe_src, empty, !o_strobe)

endmodule
